// ===== hw/rtl/lrsd_pkg.sv =====
package lrsd_pkg;

  localparam int MUL_A_W   = 96;
  localparam int MUL_B_W   = 64;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int SQ_ROOT_W = 42;
  localparam int SQ_RAD_W  = 2 * SQ_ROOT_W;
  localparam int DIV_Q_W   = 80;
  localparam int LL_W      = 31;
  localparam int Q40_W     = 40;
  localparam int VAR_W     = 64;
  localparam int OUT_DATA_W = 184;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 3;

  localparam logic [Q40_W-1:0] Q40_MAX = '1;
  localparam logic [LL_W-1:0]  LL_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RMS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEV  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACT  = 3'd6;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_BOTH = 2'd1,
    EV_LL   = 2'd2,
    EV_RMS  = 2'd3
  } event_code_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_CHECK, S_DIV, S_RSQRT, S_FSQ, S_TSQRT, S_TMUL,
    S_DECIDE, S_EPICK, S_EAD, S_EDD, S_EDDA, S_EVAR, S_OUT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hw/rtl/lrsd_accum.sv =====
module lrsd_accum import lrsd_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int MAX_BLOCK_SAMPLES = 4096,
  localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   add_en,
  input  logic                   clear,
  output logic [LL_W-1:0]        ll_acc,
  output logic [VAR_W-1:0]       sq_acc,
  output logic [CNT_W-1:0]       cnt,
  output logic [31:0]            total
);

  logic [SAMPLE_BITS-1:0]   prev_r;
  logic [2*SAMPLE_BITS-1:0] sq_r;
  logic [SAMPLE_BITS:0]     ad_r;
  logic                     take_r, haspre_r;
  logic [LL_W-1:0]          ll_r;
  logic [VAR_W-1:0]         sq_acc_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [31:0]              total_r;

  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]        ad_c;
  logic [SAMPLE_BITS-1:0]      mag;
  logic [VAR_W:0]              sq_sum;
  logic [LL_W+SAMPLE_BITS:0]   ll_sum;
  logic                        room;

  always_comb begin
    diff   = $signed({sample[SAMPLE_BITS-1], sample}) - $signed({prev_r[SAMPLE_BITS-1], prev_r});
    ad_c   = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
    mag    = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    room   = cnt_r < CNT_W'(MAX_BLOCK_SAMPLES);
    sq_sum = {1'b0, sq_acc_r} + (VAR_W + 1)'(sq_r);
    ll_sum = (LL_W + SAMPLE_BITS + 1)'(ll_r) + (LL_W + SAMPLE_BITS + 1)'(ad_r);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sq_r     <= mag * mag;
      ad_r     <= ad_c;
      haspre_r <= cnt_r != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      take_r   <= 1'b0;
      ll_r     <= '0;
      sq_acc_r <= '0;
      cnt_r    <= '0;
      total_r  <= '0;
    end else begin
      if (take) begin
        take_r  <= room;
        total_r <= total_r + 32'd1;
        if (room) begin
          prev_r <= sample;
        end
      end
      if (clear) begin
        ll_r     <= '0;
        sq_acc_r <= '0;
        cnt_r    <= '0;
      end else if (add_en && take_r) begin
        sq_acc_r <= sq_sum[VAR_W] ? '1 : sq_sum[VAR_W-1:0];
        if (haspre_r) begin
          ll_r <= (ll_sum > (LL_W + SAMPLE_BITS + 1)'(LL_MAX)) ? LL_MAX : ll_sum[LL_W-1:0];
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign ll_acc = ll_r;
  assign sq_acc = sq_acc_r;
  assign cnt    = cnt_r;
  assign total  = total_r;

endmodule

// ===== hw/rtl/lrsd_mul.sv =====
module lrsd_mul import lrsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output unit_stat_t         stat,
  output logic [MUL_P_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_B_W + 1);

  logic [MUL_P_W-1:0] acc_r;
  logic [MUL_A_W-1:0] a_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;
  logic [MUL_A_W:0]   sum;

  always_comb begin
    sum = {1'b0, acc_r[MUL_P_W-1:MUL_B_W]} + (acc_r[0] ? {1'b0, a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= {{MUL_A_W{1'b0}}, b};
      a_r   <= a;
    end else if (busy_r) begin
      acc_r <= {sum, acc_r[MUL_B_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign prod = acc_r;

endmodule

// ===== hw/rtl/lrsd_sqrt.sv =====
module lrsd_sqrt import lrsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SQ_RAD_W-1:0]  rad,
  output unit_stat_t           stat,
  output logic [SQ_ROOT_W-1:0] root
);

  localparam int REM_W = SQ_ROOT_W + 2;
  localparam int CNT_W = $clog2(SQ_ROOT_W + 1);

  logic [SQ_RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]     rem_r;
  logic [SQ_ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic [REM_W+1:0]     rem2, trial, diff;
  logic                 ge;

  always_comb begin
    rem2  = {rem_r, rad_r[SQ_RAD_W-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    ge    = rem2 >= trial;
    diff  = ge ? (rem2 - trial) : rem2;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQ_RAD_W-3:0], 2'b00};
      rem_r  <= diff[REM_W-1:0];
      root_r <= {root_r[SQ_ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign root = root_r;

endmodule

// ===== hw/rtl/lrsd_div.sv =====
module lrsd_div import lrsd_pkg::*; #(
  parameter int DEN_W = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_Q_W-1:0] num,
  input  logic [DEN_W-1:0]   den,
  output unit_stat_t         stat,
  output logic [DIV_Q_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_Q_W + 1);

  logic [DIV_Q_W-1:0] q_r;
  logic [DEN_W-1:0]   den_r, rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;
  logic [DEN_W:0]     rem2, diff;
  logic               ge;

  always_comb begin
    rem2 = {rem_r, q_r[DIV_Q_W-1]};
    ge   = rem2 >= {1'b0, den_r};
    diff = ge ? (rem2 - {1'b0, den_r}) : rem2;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_Q_W-2:0], ge};
      rem_r <= diff[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign quot = q_r;

endmodule

// ===== hw/rtl/line_length_rms_seizure_detector.sv =====
// A sample without tlast is accepted (S_IDLE) and then accumulated (S_ACC).
// A block-closing word goes straight to the output when gated; otherwise the
// divider (blocks of two or more samples), up to three square roots and up to
// eleven passes of the shared 64-step multiplier compute its result.
// Throughput: one word at a time; in_tready is high only between words.
// Reset: synchronous active-low rst_n resets control, feature and config state.
module line_length_rms_seizure_detector import lrsd_pkg::*; #(
  parameter int MAX_BLOCK_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 24,
  localparam int IN_W  = ((SAMPLE_BITS + 32 + 7) / 8) * 8,
  localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // sample_value, time_us
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // line_length_value, rms_value,
                                            // line_length_threshold, rms_threshold,
                                            // samples_seen
  output logic [OUT_USER_W-1:0] out_tuser,  // event_code, gated
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  logic [15:0] alpha_r, gain_ll_r, gain_rms_r, warm_cfg_r;
  logic [31:0] min_dev_r, refr_time_r;
  logic [7:0]  persist_cfg_r;

  seq_state_t state_r, state_nxt;
  logic       feat_r, feat_nxt;
  logic       run_r, run_nxt;

  logic                  last_r;
  logic [31:0]           time_r;
  logic [LL_W-1:0]       lf_ll_r;
  logic [Q40_W-1:0]      lf_rms_r;
  logic [Q40_W-1:0]      thr_r [2];
  logic [Q40_W-1:0]      mean_r [2];
  logic [VAR_W-1:0]      var_r [2];
  logic [VAR_W-1:0]      f_r;
  logic [Q40_W:0]        d_r;
  logic [7:0]            ll_pers_r, rms_pers_r;
  logic [31:0]           refr_end_r;
  logic [15:0]           warm_r;
  logic [1:0]            mask_r;
  event_code_t           ev_r;
  logic                  gated_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic                  in_fire, out_free, gate;
  logic [LL_W-1:0]       ll_acc;
  logic [VAR_W-1:0]      sq_acc;
  logic [CNT_W-1:0]      cnt;
  logic [31:0]           total;

  unit_stat_t            mul_stat, sqrt_stat, div_stat;
  logic                  mul_start, sqrt_start, div_start, unit_done;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_P_W-1:0]    prod;
  logic [SQ_RAD_W-1:0]   sq_rad;
  logic [SQ_ROOT_W-1:0]  root;
  logic [DIV_Q_W-1:0]    quot;

  logic [Q40_W:0]        x_sel, d_c;
  logic [Q40_W-1:0]      m_sel;
  logic                  x_ge;
  logic [VAR_W-1:0]      v_sel, term64, sum64;
  logic [VAR_W:0]        sum65;
  logic [VAR_W+7:0]      v72, rad_t;
  logic [15:0]           gain_sel;
  logic [16:0]           one_minus_a;
  logic [50:0]           thr_sum;
  logic [41:0]           m_up, m_dn, m_new;
  logic [57:0]           p_rnd;

  logic                  warm, ll_over, rms_over, ll_hit, rms_hit;
  logic [7:0]            ll_p_n, rms_p_n;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign gate      = time_r < refr_end_r;
  assign unit_done = mul_stat.done || sqrt_stat.done || div_stat.done;

  lrsd_accum #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (in_fire),
    .sample (in_tdata[SAMPLE_BITS-1:0]),
    .add_en (state_r == S_ACC),
    .clear  (state_r == S_OUT && out_free),
    .ll_acc (ll_acc),
    .sq_acc (sq_acc),
    .cnt    (cnt),
    .total  (total)
  );

  lrsd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (prod)
  );

  lrsd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sq_rad),
    .stat  (sqrt_stat),
    .root  (root)
  );

  lrsd_div #(.DEN_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({sq_acc, 16'd0}),
    .den   (cnt),
    .stat  (div_stat),
    .quot  (quot)
  );

  // feature datapath
  always_comb begin
    x_sel = feat_r ? {1'b0, lf_rms_r} : {2'b00, lf_ll_r, 8'd0};
    m_sel = mean_r[feat_r];
    x_ge  = x_sel >= {1'b0, m_sel};
    d_c   = x_ge ? (x_sel - {1'b0, m_sel}) : ({1'b0, m_sel} - x_sel);
    v_sel = var_r[feat_r];
    v72   = {v_sel, 8'd0};
    rad_t = ({8'd0, f_r} <= v72) ? v72 : {8'd0, f_r};
    gain_sel    = feat_r ? gain_rms_r : gain_ll_r;
    one_minus_a = 17'h10000 - {1'b0, alpha_r};
    term64 = (|prod[MUL_P_W-1:88]) ? '1 : prod[87:24];
    sum65  = {1'b0, v_sel} + {1'b0, term64};
    sum64  = sum65[VAR_W] ? '1 : sum65[VAR_W-1:0];
    thr_sum = {11'd0, m_sel} + prod[58:8];
    m_up  = {2'b00, m_sel} + {1'b0, prod[56:16]};
    p_rnd = {1'b0, prod[56:0]} + 58'd65535;
    m_dn  = {2'b00, m_sel} - p_rnd[57:16];
    m_new = x_ge ? m_up : m_dn;
  end

  // persistence and event decision
  always_comb begin
    warm      = warm_r < warm_cfg_r;
    ll_over   = {1'b0, lf_ll_r, 8'd0} >= thr_r[0];
    rms_over  = lf_rms_r >= thr_r[1];
    ll_p_n    = ll_over ? ((ll_pers_r == 8'hFF) ? ll_pers_r : ll_pers_r + 8'd1) : 8'd0;
    rms_p_n   = rms_over ? ((rms_pers_r == 8'hFF) ? rms_pers_r : rms_pers_r + 8'd1) : 8'd0;
    ll_hit    = ll_p_n >= persist_cfg_r;
    rms_hit   = rms_p_n >= persist_cfg_r;
  end

  always_comb begin
    state_nxt = state_r;
    feat_nxt  = feat_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = last_r ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (gate) state_nxt = S_OUT;
        else if (cnt >= CNT_W'(2)) state_nxt = S_DIV;
        else state_nxt = S_FSQ;
      end
      S_DIV: begin
        if (div_stat.done) state_nxt = S_RSQRT;
      end
      S_RSQRT: begin
        if (sqrt_stat.done) state_nxt = S_FSQ;
      end
      S_FSQ: begin
        if (mul_stat.done) begin
          state_nxt = S_TSQRT;
          feat_nxt  = 1'b0;
        end
      end
      S_TSQRT: begin
        if (sqrt_stat.done) state_nxt = S_TMUL;
      end
      S_TMUL: begin
        if (mul_stat.done) begin
          state_nxt = feat_r ? S_DECIDE : S_TSQRT;
          feat_nxt  = !feat_r;
        end
      end
      S_DECIDE: begin
        state_nxt = S_EPICK;
        feat_nxt  = 1'b0;
      end
      S_EPICK: begin
        if (mask_r[feat_r]) state_nxt = S_EAD;
        else if (feat_r) state_nxt = S_OUT;
        else feat_nxt = 1'b1;
      end
      S_EAD: begin
        if (mul_stat.done) state_nxt = S_EDD;
      end
      S_EDD: begin
        if (mul_stat.done) state_nxt = S_EDDA;
      end
      S_EDDA: begin
        if (mul_stat.done) state_nxt = S_EVAR;
      end
      S_EVAR: begin
        if (mul_stat.done) begin
          state_nxt = feat_r ? S_OUT : S_EPICK;
          feat_nxt  = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sq_rad     = {12'd0, rad_t};
    case (state_r)
      S_DIV: div_start = !run_r;
      S_RSQRT: begin
        sqrt_start = !run_r;
        sq_rad     = {4'd0, quot};
      end
      S_TSQRT: sqrt_start = !run_r;
      S_FSQ: begin
        mul_start = !run_r;
        mul_a     = {64'd0, min_dev_r};
        mul_b     = {32'd0, min_dev_r};
      end
      S_TMUL: begin
        mul_start = !run_r;
        mul_a     = {54'd0, root};
        mul_b     = {48'd0, gain_sel};
      end
      S_EAD: begin
        mul_start = !run_r;
        mul_a     = {55'd0, d_c};
        mul_b     = {48'd0, alpha_r};
      end
      S_EDD: begin
        mul_start = !run_r;
        mul_a     = {55'd0, d_r};
        mul_b     = {23'd0, d_r};
      end
      S_EDDA: begin
        mul_start = !run_r;
        mul_a     = prod[MUL_A_W-1:0];
        mul_b     = {48'd0, alpha_r};
      end
      S_EVAR: begin
        mul_start = !run_r;
        mul_a     = {32'd0, sum64};
        mul_b     = {47'd0, one_minus_a};
      end
      default: ;
    endcase
    run_nxt = unit_done ? 1'b0 : ((mul_start || sqrt_start || div_start) ? 1'b1 : run_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      feat_r  <= 1'b0;
      run_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      feat_r  <= feat_nxt;
      run_r   <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r       <= 16'd655;
      gain_ll_r     <= 16'd768;
      gain_rms_r    <= 16'd768;
      min_dev_r     <= 32'd256;
      warm_cfg_r    <= 16'd16;
      persist_cfg_r <= 8'd3;
      refr_time_r   <= 32'd1000000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALPHA:    alpha_r       <= cfg_data[15:0];
        CFG_GAIN_LL:  gain_ll_r     <= cfg_data[15:0];
        CFG_GAIN_RMS: gain_rms_r    <= cfg_data[15:0];
        CFG_MIN_DEV:  min_dev_r     <= cfg_data;
        CFG_WARMUP:   warm_cfg_r    <= cfg_data[15:0];
        CFG_PERSIST:  persist_cfg_r <= cfg_data[7:0];
        CFG_REFRACT:  refr_time_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_r <= in_tlast;
      time_r <= in_tdata[SAMPLE_BITS+31:SAMPLE_BITS];
    end
    if (state_r == S_FSQ && mul_stat.done) f_r <= prod[VAR_W-1:0];
    if (state_r == S_EAD && mul_start) d_r <= d_c;
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {1'b0, total, thr_r[1], thr_r[0], lf_rms_r, lf_ll_r};
      out_user_r <= {gated_r, ev_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_ll_r     <= '0;
      lf_rms_r    <= '0;
      thr_r[0]    <= '0;
      thr_r[1]    <= '0;
      mean_r[0]   <= '0;
      mean_r[1]   <= '0;
      var_r[0]    <= '0;
      var_r[1]    <= '0;
      ll_pers_r   <= '0;
      rms_pers_r  <= '0;
      refr_end_r  <= '0;
      warm_r      <= '0;
      mask_r      <= '0;
      ev_r        <= EV_NONE;
      gated_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_CHECK: begin
          gated_r <= gate;
          ev_r    <= EV_NONE;
          if (!gate) begin
            lf_ll_r <= (cnt >= CNT_W'(2)) ? ll_acc : '0;
            if (cnt < CNT_W'(2)) lf_rms_r <= '0;
          end
        end
        S_RSQRT: begin
          if (sqrt_stat.done) lf_rms_r <= root[Q40_W-1:0];
        end
        S_TMUL: begin
          if (mul_stat.done) begin
            thr_r[feat_r] <= (|thr_sum[50:Q40_W]) ? Q40_MAX : thr_sum[Q40_W-1:0];
          end
        end
        S_DECIDE: begin
          if (warm) begin
            mask_r <= 2'b11;
            warm_r <= warm_r + 16'd1;
            ev_r   <= EV_NONE;
          end else begin
            mask_r <= {!rms_over, !ll_over};
            if (ll_hit && rms_hit) begin
              ll_pers_r  <= '0;
              rms_pers_r <= '0;
              refr_end_r <= time_r + refr_time_r;
              ev_r       <= EV_BOTH;
            end else if (ll_hit) begin
              ll_pers_r  <= '0;
              rms_pers_r <= rms_p_n;
              ev_r       <= EV_LL;
            end else if (rms_hit) begin
              ll_pers_r  <= ll_p_n;
              rms_pers_r <= '0;
              ev_r       <= EV_RMS;
            end else begin
              ll_pers_r  <= ll_p_n;
              rms_pers_r <= rms_p_n;
              ev_r       <= EV_NONE;
            end
          end
        end
        S_EAD: begin
          if (mul_stat.done) begin
            mean_r[feat_r] <= (|m_new[41:Q40_W]) ? Q40_MAX : m_new[Q40_W-1:0];
          end
        end
        S_EVAR: begin
          if (mul_stat.done) begin
            var_r[feat_r] <= (|prod[MUL_P_W-1:80]) ? '1 : prod[79:16];
          end
        end
        default: ;
      endcase
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_units_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mul_stat.busy && !sqrt_stat.busy && !div_stat.busy)
    else $error("arithmetic unit busy while accepting samples");

  a_gated_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tuser[1:0] == EV_NONE))
    else $error("gated block reported an event");

  a_both_clears_persist: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |=> (ev_r != EV_BOTH) || (ll_pers_r == 8'd0 && rms_pers_r == 8'd0))
    else $error("persistence counters not cleared after onset of both features");

endmodule

// ===== dv/line_length_rms_seizure_detector_test.sv =====
module line_length_rms_seizure_detector_test import lrsd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_MAX = 4096;
  localparam int IN_W = 56;
  localparam logic [63:0] LL_SAT = 64'h7FFF_FFFF;
  localparam logic [63:0] Q40_SAT = 64'hFF_FFFF_FFFF;

  class detector_board;
    typedef struct {
      event_code_t code;
      bit gated;
      bit [30:0] ll;
      bit [39:0] rms;
      bit [39:0] thr_ll;
      bit [39:0] thr_rms;
      bit [31:0] total;
    } block_result_t;

    bit [63:0] alpha, gain_ll, gain_rms, min_dev, warmup, persist, refract;
    longint prev;
    bit [63:0] ll_acc, sq_acc, cnt;
    bit [63:0] ll_mean, ll_var, rms_avg, rms_var;
    bit [63:0] ll_pers, rms_pers, refr_end, warm_done;
    bit [31:0] total;
    bit [63:0] feat[4];
    block_result_t expected_blocks[$];
    int errors;
    int checked;
    int onsets;
    int gated_seen;

    function void reset();
      alpha = 655; gain_ll = 768; gain_rms = 768; min_dev = 256;
      warmup = 16; persist = 3; refract = 1000000;
      prev = 0; ll_acc = 0; sq_acc = 0; cnt = 0;
      ll_mean = 0; ll_var = 0; rms_avg = 0; rms_var = 0;
      ll_pers = 0; rms_pers = 0; refr_end = 0; warm_done = 0; total = 0;
      foreach (feat[i]) feat[i] = 0;
    endfunction

    function void write_cfg(bit [CFG_IDX_W-1:0] idx, bit [31:0] v);
      case (idx)
        CFG_ALPHA:    alpha = v[15:0];
        CFG_GAIN_LL:  gain_ll = v[15:0];
        CFG_GAIN_RMS: gain_rms = v[15:0];
        CFG_MIN_DEV:  min_dev = v;
        CFG_WARMUP:   warmup = v[15:0];
        CFG_PERSIST:  persist = v[7:0];
        CFG_REFRACT:  refract = v;
        default: ;
      endcase
    endfunction

    function bit [63:0] isqrt(bit [127:0] x);
      bit [63:0] r;
      bit [63:0] c;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return r;
    endfunction

    function void ewma(input bit [63:0] x, inout bit [63:0] m, inout bit [63:0] v);
      bit [63:0] d, term, sum;
      bit [127:0] w;
      if (x >= m) begin
        d = x - m;
        m = m + ((alpha * d) >> 16);
      end else begin
        d = m - x;
        m = m - ((alpha * d + 65535) >> 16);
      end
      if (m > Q40_SAT) m = Q40_SAT;
      w = {64'd0, d} * {64'd0, d};
      w = (w * {64'd0, alpha}) >> 24;
      term = (w[127:64] != 0) ? '1 : w[63:0];
      sum = v + term;
      if (sum < term) sum = '1;
      w = ({64'd0, sum} * {64'd0, 64'd65536 - alpha}) >> 16;
      v = (w[127:64] != 0) ? '1 : w[63:0];
    endfunction

    function bit [63:0] threshold(bit [63:0] m, bit [63:0] v, bit [63:0] g);
      bit [127:0] vv, ff;
      bit [63:0] sd, t;
      vv = {64'd0, v} << 8;
      ff = {64'd0, min_dev} * {64'd0, min_dev};
      sd = isqrt((ff <= vv) ? vv : ff);
      t = m + ((g * sd) >> 8);
      return (t > Q40_SAT) ? Q40_SAT : t;
    endfunction

    function event_code_t close_block(bit [63:0] t_us);
      bit [63:0] ll, rms, llq, t_ll, t_rms;
      bit ll_hi, rms_hi, ll_p, rms_p;
      ll = 0;
      rms = 0;
      if (cnt >= 2) begin
        ll = ll_acc;
        rms = isqrt({48'd0, sq_acc, 16'd0} / {64'd0, cnt});
      end
      llq = ll << 8;
      t_ll = threshold(ll_mean, ll_var, gain_ll);
      t_rms = threshold(rms_avg, rms_var, gain_rms);
      feat[0] = ll; feat[1] = rms; feat[2] = t_ll; feat[3] = t_rms;
      if (warm_done < warmup) begin
        ewma(llq, ll_mean, ll_var);
        ewma(rms, rms_avg, rms_var);
        warm_done++;
        return EV_NONE;
      end
      ll_hi = llq >= t_ll;
      rms_hi = rms >= t_rms;
      if (!ll_hi) ewma(llq, ll_mean, ll_var);
      if (!rms_hi) ewma(rms, rms_avg, rms_var);
      if (ll_hi) begin
        if (ll_pers < 255) ll_pers++;
      end else begin
        ll_pers = 0;
      end
      if (rms_hi) begin
        if (rms_pers < 255) rms_pers++;
      end else begin
        rms_pers = 0;
      end
      ll_p = ll_pers >= persist;
      rms_p = rms_pers >= persist;
      if (ll_p && rms_p) begin
        ll_pers = 0;
        rms_pers = 0;
        refr_end = (t_us + refract) & 64'hFFFF_FFFF;
        return EV_BOTH;
      end
      if (ll_p) begin
        ll_pers = 0;
        return EV_LL;
      end
      if (rms_p) begin
        rms_pers = 0;
        return EV_RMS;
      end
      return EV_NONE;
    endfunction

    function void note_word(bit [23:0] raw, bit last, bit [31:0] t_us);
      longint s, d;
      bit [63:0] mag, sq;
      block_result_t r;
      s = $signed(raw);
      total++;
      if (cnt < BLOCK_MAX) begin
        mag = (s < 0) ? -s : s;
        sq = mag * mag;
        sq_acc += sq;
        if (sq_acc < sq) sq_acc = '1;
        if (cnt > 0) begin
          d = s - prev;
          ll_acc += (d < 0) ? -d : d;
          if (ll_acc > LL_SAT) ll_acc = LL_SAT;
        end
        prev = s;
        cnt++;
      end
      if (!last) return;
      r.code = EV_NONE;
      r.gated = 0;
      if (t_us < refr_end) r.gated = 1;
      else r.code = close_block(t_us);
      ll_acc = 0; sq_acc = 0; cnt = 0;
      r.ll = feat[0][30:0];
      r.rms = feat[1][39:0];
      r.thr_ll = feat[2][39:0];
      r.thr_rms = feat[3][39:0];
      r.total = total;
      expected_blocks.push_back(r);
    endfunction

    function void check_block(bit [OUT_DATA_W-1:0] td, bit [OUT_USER_W-1:0] tu);
      block_result_t e;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result %h / %h", $time, td, tu);
        errors++;
        return;
      end
      e = expected_blocks.pop_front();
      checked++;
      if (e.code != EV_NONE) onsets++;
      if (e.gated) gated_seen++;
      if (tu[1:0] != e.code) begin
        $display("%0t: event_code exp %0d got %0d", $time, e.code, tu[1:0]);
        errors++;
      end
      if (tu[2] != e.gated) begin
        $display("%0t: gated exp %0d got %0d", $time, e.gated, tu[2]);
        errors++;
      end
      if (td[30:0] != e.ll) begin
        $display("%0t: line_length exp %0d got %0d", $time, e.ll, td[30:0]);
        errors++;
      end
      if (td[70:31] != e.rms) begin
        $display("%0t: rms exp %0d got %0d", $time, e.rms, td[70:31]);
        errors++;
      end
      if (td[110:71] != e.thr_ll) begin
        $display("%0t: ll threshold exp %0d got %0d", $time, e.thr_ll, td[110:71]);
        errors++;
      end
      if (td[150:111] != e.thr_rms) begin
        $display("%0t: rms threshold exp %0d got %0d", $time, e.thr_rms, td[150:111]);
        errors++;
      end
      if (td[182:151] != e.total) begin
        $display("%0t: samples_seen exp %0d got %0d", $time, e.total, td[182:151]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  detector_board board = new();
  bit quiet = 0;
  bit [31:0] clock_us = 0;
  int words_sent = 0;

  line_length_rms_seizure_detector dut (.*);

  always #1 clk = ~clk;

  task automatic send_word(bit [23:0] s, bit last, bit [31:0] t_us);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {t_us, s};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    board.note_word(s, last, t_us);
    words_sent++;
  endtask

  // amp 0 means full-scale random samples
  task automatic send_block(int n, int amp);
    bit [23:0] s;
    for (int i = 0; i < n; i++) begin
      if (amp == 0) s = 24'($urandom);
      else begin
        s = 24'($urandom_range(0, amp));
        if ($urandom_range(0, 1)) s = -s;
      end
      if (i == n - 1) begin
        if ($urandom_range(0, 30) == 0) clock_us = $urandom;
        else clock_us += $urandom_range(200, 3000);
        send_word(s, 1'b1, clock_us);
      end else begin
        send_word(s, 1'b0, $urandom);
      end
    end
  endtask

  task automatic settle();
    in_tvalid <= 0;
    @(posedge clk);
    while (board.expected_blocks.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.write_cfg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // receiver: random backpressure, one long hold-off after the 20th block
  initial begin
    int idle_left;
    int hold;
    bit held;
    idle_left = 0;
    hold = 0;
    held = 0;
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        board.check_block(out_tdata, out_tuser);
        if (board.checked == 20 && !held) begin
          held = 1;
          hold = 3000;
        end
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 0;
      end else if (quiet) begin
        out_tready <= 1;
      end else if (idle_left > 0) begin
        idle_left--;
        out_tready <= 0;
      end else if ($urandom_range(0, 3) == 0) begin
        idle_left = $urandom_range(0, 2);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int n, amp, burst, sent;
    board.reset();
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= '0;
    in_tlast <= 0;
    cfg_valid <= 0;
    cfg_index <= CFG_ALPHA;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // short blocks, extreme samples, warm-up under default settings
    send_word(24'h7FFFFF, 1'b1, 32'd0);
    send_word(24'h800000, 1'b0, 32'hFFFFFFFF);
    send_word(24'h7FFFFF, 1'b1, 32'd10);
    send_word(24'd0, 1'b0, 32'd0);
    send_word(24'd0, 1'b1, 32'd20);
    send_block(4, 0);
    settle();

    // zero persistence, no warm-up, wrapping refractory end
    write_reg(CFG_WARMUP, 32'd0);
    write_reg(CFG_PERSIST, 32'd0);
    write_reg(CFG_REFRACT, 32'hFFFFFFFF);
    write_reg(CFG_MIN_DEV, 32'hFFFFFFFF);
    write_reg(CFG_GAIN_LL, 32'hFFFF);
    write_reg(CFG_GAIN_RMS, 32'd0);
    send_word(24'h000100, 1'b0, 32'd0);
    send_word(24'hFFFF00, 1'b1, 32'hFFFFFFF0);
    send_word(24'h123456, 1'b1, 32'd5);
    send_word(24'h000001, 1'b0, 32'd0);
    send_word(24'h7FFFFF, 1'b1, 32'hFFFFFFFF);
    send_block(3, 8000000);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      quiet = (ph == 5);
      write_reg(CFG_ALPHA, ph == 0 ? 32'hFFFF : ph == 1 ? 32'd0 : $urandom_range(300, 9000));
      write_reg(CFG_GAIN_LL, ph == 4 ? 32'hFFFF : $urandom_range(128, 1024));
      write_reg(CFG_GAIN_RMS, ph == 4 ? 32'd0 : $urandom_range(128, 1024));
      write_reg(CFG_MIN_DEV, ph == 3 ? 32'd0 : $urandom_range(16, 4096));
      write_reg(CFG_WARMUP, ph == 1 ? 32'hFFFF : $urandom_range(0, 8));
      write_reg(CFG_PERSIST, ph == 2 ? 32'hFF : $urandom_range(1, 4));
      write_reg(CFG_REFRACT, ph == 3 ? 32'd0 : $urandom_range(2000, 20000));
      sent = 0;
      burst = 0;
      while (sent < 300) begin
        if (burst == 0 && $urandom_range(0, 7) == 0) burst = $urandom_range(3, 8);
        if (burst > 0) begin
          burst--;
          amp = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(50000, 2000000);
        end else begin
          amp = $urandom_range(50, 2000);
        end
        n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(4, 24);
        send_block(n, amp);
        sent += n;
      end
      settle();
    end

    repeat (100) @(posedge clk);
    $display("Checked %0d blocks from %0d samples over 8 settings", board.checked, words_sent);
    $display("Onset reports %0d, refractory-gated blocks %0d", board.onsets, board.gated_seen);
    if (board.errors == 0 && board.expected_blocks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
